@@ rtl/rolling_window_percentile_defines.svh @@
// Assertion macros of the rolling window percentile checker.
`ifndef ROLLING_WINDOW_PERCENTILE_DEFINES_SVH
`define ROLLING_WINDOW_PERCENTILE_DEFINES_SVH

// Same-cycle implication.
`define RWP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RWP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rwp_pkg.sv @@
// Types and constants of the rolling window percentile block.
`default_nettype none

package rwp_pkg;

   localparam int WinDepth = 64;
   localparam int AddrW    = $clog2(WinDepth);
   localparam int CntW     = $clog2(WinDepth + 1);
   localparam int SampleW  = 64;
   localparam int FracW    = 17;
   localparam int FracBits = 16;
   localparam int ProdW    = FracW + CntW;
   localparam int RankW    = ProdW - FracBits;

   localparam logic OpPush  = 1'b0;
   localparam logic OpQuery = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [SampleW-1:0] sample_value;
      logic [FracW-1:0]   rank_fraction;
   } req_item_type;

   typedef struct packed {
      logic [SampleW-1:0] selected_value;
      logic [CntW-1:0]    live_entries;
      logic               window_full;
   } rsp_item_type;

   typedef struct packed {
      logic               we;
      logic [AddrW-1:0]   waddr;
      logic [SampleW-1:0] wdata;
      logic               re;
      logic [AddrW-1:0]   raddr;
   } ram_cmd_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } seq_res_type;

endpackage

`default_nettype wire

@@ rtl/rwp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rwp_ram #(
   parameter int Width = 64,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/rwp_seq.sv @@
// Sequencer: maintains the arrival ring and the sorted copy, answers rank queries.
`default_nettype none

module rwp_seq import rwp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_item_type       req_item,
   output ram_cmd_type             ring_cmd,
   input  wire logic [SampleW-1:0] ring_rdata,
   output ram_cmd_type             sort_cmd,
   input  wire logic [SampleW-1:0] sort_rdata,
   output seq_res_type             res,
   input  wire logic               res_take
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVICT,
      ST_DEL,
      ST_INS,
      ST_INS_LAST,
      ST_FIN,
      ST_Q_MUL,
      ST_Q_RANK,
      ST_Q_RD,
      ST_Q_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [AddrW-1:0]   wpos_ff, wpos_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [AddrW-1:0]   rd_ff, rd_in;
   logic               rd_go_ff, rd_go_in;
   logic [AddrW-1:0]   pj_ff, pj_in;
   logic               dv_ff, dv_in;
   logic               rm_ff, rm_in;
   logic [SampleW-1:0] val_ff, val_in;
   logic [SampleW-1:0] old_ff, old_in;
   logic [SampleW-1:0] sel_ff, sel_in;
   logic [FracW-1:0]   frac_ff, frac_in;
   logic [ProdW-1:0]   prod_ff, prod_in;

   logic               full_w;
   logic [CntW-1:0]    top_w;
   logic [RankW-1:0]   rank_w;
   logic [CntW-1:0]    rank_sel;

   assign full_w    = (count_ff == CntW'(WinDepth));
   assign top_w     = count_ff - CntW'(1);
   assign rank_w    = prod_ff[ProdW-1:FracBits];
   assign rank_sel  = (rank_w > RankW'(top_w)) ? top_w : rank_w[CntW-1:0];
   assign req_stall = reset || (state_ff != ST_IDLE);

   assign res.valid               = (state_ff == ST_Q_OUT);
   assign res.item.selected_value = sel_ff;
   assign res.item.live_entries   = count_ff;
   assign res.item.window_full    = full_w;

   always_comb begin
      state_in = state_ff;
      wpos_in  = wpos_ff;
      count_in = count_ff;
      rd_in    = rd_ff;
      rd_go_in = rd_go_ff;
      pj_in    = pj_ff;
      dv_in    = 1'b0;
      rm_in    = rm_ff;
      val_in   = val_ff;
      old_in   = old_ff;
      sel_in   = sel_ff;
      frac_in  = frac_ff;
      prod_in  = prod_ff;
      ring_cmd = '0;
      sort_cmd = '0;

      case (state_ff)
         ST_IDLE: begin
            // oldest slot is read ahead so it is ready if the window is full
            ring_cmd.re    = 1'b1;
            ring_cmd.raddr = wpos_ff;
            if (req_valid) begin
               val_in  = req_item.sample_value;
               frac_in = req_item.rank_fraction;
               if (req_item.opcode == OpPush) begin
                  state_in = ST_EVICT;
               end else begin
                  state_in = ST_Q_MUL;
               end
            end
         end

         ST_EVICT: begin
            old_in         = ring_rdata;
            ring_cmd.we    = 1'b1;
            ring_cmd.waddr = wpos_ff;
            ring_cmd.wdata = val_ff;
            rm_in          = 1'b0;
            if (full_w) begin
               rd_in    = '0;
               rd_go_in = 1'b1;
               state_in = ST_DEL;
            end else if (count_ff == '0) begin
               state_in = ST_INS_LAST;
            end else begin
               rd_in    = top_w[AddrW-1:0];
               rd_go_in = 1'b1;
               state_in = ST_INS;
            end
         end

         // upward pass: drop one copy of the evicted sample, close the gap
         ST_DEL: begin
            if (rd_go_ff) begin
               sort_cmd.re    = 1'b1;
               sort_cmd.raddr = rd_ff;
               pj_in          = rd_ff;
               dv_in          = 1'b1;
               if (rd_ff == AddrW'(WinDepth - 1)) begin
                  rd_go_in = 1'b0;
               end else begin
                  rd_in = rd_ff + AddrW'(1);
               end
            end
            if (dv_ff) begin
               if (rm_ff) begin
                  sort_cmd.we    = 1'b1;
                  sort_cmd.waddr = pj_ff - AddrW'(1);
                  sort_cmd.wdata = sort_rdata;
               end else if (sort_rdata == old_ff) begin
                  rm_in = 1'b1;
               end
               if (pj_ff == AddrW'(WinDepth - 1)) begin
                  rd_in    = AddrW'(WinDepth - 2);
                  rd_go_in = 1'b1;
                  dv_in    = 1'b0;
                  state_in = ST_INS;
               end
            end
         end

         // downward pass: shift larger entries up one, drop the new sample in
         ST_INS: begin
            if (rd_go_ff) begin
               sort_cmd.re    = 1'b1;
               sort_cmd.raddr = rd_ff;
               pj_in          = rd_ff;
               dv_in          = 1'b1;
               if (rd_ff == '0) begin
                  rd_go_in = 1'b0;
               end else begin
                  rd_in = rd_ff - AddrW'(1);
               end
            end
            if (dv_ff) begin
               sort_cmd.we    = 1'b1;
               sort_cmd.waddr = pj_ff + AddrW'(1);
               if (sort_rdata > val_ff) begin
                  sort_cmd.wdata = sort_rdata;
                  if (pj_ff == '0) begin
                     rd_go_in = 1'b0;
                     state_in = ST_INS_LAST;
                  end
               end else begin
                  sort_cmd.wdata = val_ff;
                  rd_go_in       = 1'b0;
                  state_in       = ST_FIN;
               end
            end
         end

         ST_INS_LAST: begin
            sort_cmd.we    = 1'b1;
            sort_cmd.waddr = '0;
            sort_cmd.wdata = val_ff;
            state_in       = ST_FIN;
         end

         ST_FIN: begin
            if (!full_w) begin
               count_in = count_ff + CntW'(1);
            end
            if (wpos_ff == AddrW'(WinDepth - 1)) begin
               wpos_in = '0;
            end else begin
               wpos_in = wpos_ff + AddrW'(1);
            end
            state_in = ST_IDLE;
         end

         ST_Q_MUL: begin
            prod_in = ProdW'(frac_ff) * ProdW'(top_w);
            if (count_ff == '0) begin
               sel_in   = '0;
               state_in = ST_Q_OUT;
            end else begin
               state_in = ST_Q_RANK;
            end
         end

         ST_Q_RANK: begin
            sort_cmd.re    = 1'b1;
            sort_cmd.raddr = rank_sel[AddrW-1:0];
            state_in       = ST_Q_RD;
         end

         ST_Q_RD: begin
            sel_in   = sort_rdata;
            state_in = ST_Q_OUT;
         end

         ST_Q_OUT: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wpos_ff  <= '0;
         count_ff <= '0;
         rd_go_ff <= 1'b0;
         dv_ff    <= 1'b0;
         rm_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         wpos_ff  <= wpos_in;
         count_ff <= count_in;
         rd_go_ff <= rd_go_in;
         dv_ff    <= dv_in;
         rm_ff    <= rm_in;
      end
      rd_ff   <= rd_in;
      pj_ff   <= pj_in;
      val_ff  <= val_in;
      old_ff  <= old_in;
      sel_ff  <= sel_in;
      frac_ff <= frac_in;
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

@@ rtl/rolling_window_percentile.sv @@
// Rolling window percentile: top level with sample memories and result register.
//
// Input channel req_*: one item per handshake (req_valid high, req_stall low).
//   opcode push stores sample_value in the window, evicting the oldest sample
//   once the window holds WinDepth samples; it gives no result.
//   opcode query returns the sample at ascending rank
//   floor(rank_fraction * (live - 1) / 65536), clamped to the largest sample.
// Result channel rsp_*: one item per query, held while rsp_stall is high.
// A push when the window is full makes two passes over the sorted copy (one
// to remove the evicted sample, one to insert the new one) and at most the
// insert pass before that, as the sorted memory has a single read port.
// A query forms the rank, reads that entry of the sorted copy and passes it on.
// One item is worked on at a time; req_stall is high while it is and in reset.
// A finished result waits in the output register, so the next item is taken
// while the receiver stalls; a further query then waits until that result leaves.
// Reset empties the window and drops any pending result; no memory clearing
// pass is needed since only live entries are ever used.
`default_nettype none

module rolling_window_percentile import rwp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item
);

   ram_cmd_type        ring_cmd;
   ram_cmd_type        sort_cmd;
   logic [SampleW-1:0] ring_rdata;
   logic [SampleW-1:0] sort_rdata;
   seq_res_type        res;
   logic               out_free;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   rwp_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .ring_cmd   (ring_cmd),
      .ring_rdata (ring_rdata),
      .sort_cmd   (sort_cmd),
      .sort_rdata (sort_rdata),
      .res        (res),
      .res_take   (out_free)
   );

   // arrival order
   rwp_ram #(.Width(SampleW), .Depth(WinDepth)) u_ring (
      .clock   (clock),
      .wr_en   (ring_cmd.we),
      .wr_addr (ring_cmd.waddr),
      .wr_data (ring_cmd.wdata),
      .rd_en   (ring_cmd.re),
      .rd_addr (ring_cmd.raddr),
      .rd_data (ring_rdata)
   );

   // ascending copy of the live samples
   rwp_ram #(.Width(SampleW), .Depth(WinDepth)) u_sort (
      .clock   (clock),
      .wr_en   (sort_cmd.we),
      .wr_addr (sort_cmd.waddr),
      .wr_data (sort_cmd.wdata),
      .rd_en   (sort_cmd.re),
      .rd_addr (sort_cmd.raddr),
      .rd_data (sort_rdata)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (out_free) begin
         rsp_valid_in = res.valid;
         if (res.valid) begin
            rsp_item_in = res.item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

@@ rtl/rwp_checker.sv @@
// Port-level checks for the rolling window percentile block, bound to the top level.
`default_nettype none

`include "rolling_window_percentile_defines.svh"

module rwp_checker import rwp_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_item_type rsp_item
);

   `RWP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp_valid dropped while stalled")
   `RWP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_item), "rsp item changed while stalled")
   `RWP_ASSERT_NOW(a_full_flag, clock, reset, rsp_valid, rsp_item.window_full == (rsp_item.live_entries == CntW'(WinDepth)), "window_full disagrees with live_entries")
   `RWP_ASSERT_NOW(a_count_max, clock, reset, rsp_valid, rsp_item.live_entries <= CntW'(WinDepth), "live_entries above window depth")
   `RWP_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && (rsp_item.live_entries == '0), rsp_item.selected_value == '0, "empty window gave nonzero value")

endmodule

bind rolling_window_percentile rwp_checker u_rwp_checker (.*);

`default_nettype wire

@@ test/tb_rolling_window_percentile.sv @@
// Self-checking testbench of the rolling window percentile block, with a scoreboard class.
`timescale 1ns / 1ps

module tb_rolling_window_percentile;
   import rwp_pkg::*;

   localparam int CycleLimit = 1000000;
   localparam int HoldCycles = 700;
   localparam int TailCycles = 4 * WinDepth + 40;
   localparam int RandomItems = 300;
   localparam int QuietItems = 60;
   localparam int PressureItems = 16;
   localparam logic [FracW-1:0] FracOne = 17'd65536;
   localparam int MaxPrinted = 100;

   class percentile_tracker;
      logic [SampleW-1:0] window_samples [WinDepth];
      int unsigned        next_slot;
      int unsigned        held_count;
      rsp_item_type       expected_answers [$];
      int                 errors;
      int                 pushes;
      int                 evictions;
      int                 queries;
      int                 compared;

      function new();
         next_slot = 0;
         held_count = 0;
         errors = 0;
         pushes = 0;
         evictions = 0;
         queries = 0;
         compared = 0;
      endfunction

      task flag_mismatch(string what);
         errors++;
         if (errors <= MaxPrinted)
            $display("MISMATCH %0t: %s", $time, what);
      endtask

      function rsp_item_type rank_of_window(logic [FracW-1:0] frac);
         logic [SampleW-1:0] ordered [WinDepth];
         logic [SampleW-1:0] key;
         rsp_item_type       answer;
         longint unsigned    rank;
         int                 i;
         int                 j;
         answer = '0;
         answer.live_entries = CntW'(held_count);
         answer.window_full = (held_count == WinDepth);
         if (held_count > 0) begin
            for (i = 0; i < held_count; i++)
               ordered[i] = window_samples[i];
            for (i = 1; i < held_count; i++) begin
               key = ordered[i];
               j = i;
               while (j > 0 && ordered[j-1] > key) begin
                  ordered[j] = ordered[j-1];
                  j--;
               end
               ordered[j] = key;
            end
            rank = (longint'(frac) * longint'(held_count - 1)) >> FracBits;
            if (rank > held_count - 1)
               rank = held_count - 1;
            answer.selected_value = ordered[rank];
         end
         return answer;
      endfunction

      task take_request(req_item_type it);
         if (it.opcode == OpPush) begin
            pushes++;
            if (held_count == WinDepth)
               evictions++;
            window_samples[next_slot] = it.sample_value;
            next_slot = (next_slot + 1) % WinDepth;
            if (held_count < WinDepth)
               held_count++;
         end else begin
            queries++;
            expected_answers = {expected_answers, rank_of_window(it.rank_fraction)};
         end
      endtask

      task match_answer(rsp_item_type got);
         rsp_item_type want;
         if (expected_answers.size() == 0) begin
            flag_mismatch($sformatf("result %h with none expected", got));
            return;
         end
         want = expected_answers.pop_front();
         compared++;
         if (got.selected_value !== want.selected_value)
            flag_mismatch($sformatf("selected_value %h, expected %h",
                                    got.selected_value, want.selected_value));
         if (got.live_entries !== want.live_entries)
            flag_mismatch($sformatf("live_entries %0d, expected %0d",
                                    got.live_entries, want.live_entries));
         if (got.window_full !== want.window_full)
            flag_mismatch($sformatf("window_full %b, expected %b",
                                    got.window_full, want.window_full));
      endtask

      function int waiting();
         return expected_answers.size();
      endfunction

      task drain_check();
         if (expected_answers.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;

   bit quiet = 1'b0;
   bit hold_req = 1'b0;
   int cycle_count = 0;
   percentile_tracker tracker = new();

   rolling_window_percentile DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         tracker.take_request(req_item);
      if (!reset && rsp_valid && !rsp_stall)
         tracker.match_answer(rsp_item);
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin : rsp_side
      int span;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldCycles - 1) @(negedge clock);
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            span = quiet ? 1 : $urandom_range(1, 20);
            repeat (span - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b1;
            span = $urandom_range(1, 14);
            repeat (span - 1) @(negedge clock);
         end
      end
   end

   function automatic req_item_type make_item(logic op, logic [SampleW-1:0] value,
                                              logic [FracW-1:0] frac);
      req_item_type it;
      it.opcode = op;
      it.sample_value = value;
      it.rank_fraction = frac;
      return it;
   endfunction

   function automatic logic [SampleW-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return 64'(1) << $urandom_range(0, 63);
         3:       return 64'($urandom_range(0, 7));    // ties
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [FracW-1:0] pick_fraction();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return FracOne;
         2:       return 17'($urandom_range(65537, 131071));
         3:       return 17'($urandom_range(0, 65535));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic req_item_type random_item(int query_pct);
      return make_item(($urandom_range(1, 100) <= query_pct) ? OpQuery : OpPush,
                       pick_sample(), pick_fraction());
   endfunction

   task automatic send_item(req_item_type it);
      @(negedge clock);
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic maybe_idle();
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   initial begin : stimulus
      int i;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // empty window, single entry, extremes, ties, fractions at and above one
      send_item(make_item(OpQuery, '1, '0));
      send_item(make_item(OpQuery, '0, FracOne));
      send_item(make_item(OpPush, '0, '1));
      send_item(make_item(OpQuery, '0, '0));
      send_item(make_item(OpQuery, '0, '1));
      send_item(make_item(OpPush, '1, '0));
      send_item(make_item(OpPush, 64'h8000_0000_0000_0000, '0));
      send_item(make_item(OpPush, 64'd1, '0));
      send_item(make_item(OpPush, '1, '0));
      send_item(make_item(OpQuery, '1, '0));
      send_item(make_item(OpQuery, '0, 17'd16384));
      send_item(make_item(OpQuery, '0, 17'd32768));
      send_item(make_item(OpQuery, '0, 17'd65535));
      send_item(make_item(OpQuery, '0, FracOne));
      send_item(make_item(OpQuery, '0, 17'd65537));
      send_item(make_item(OpQuery, '0, '1));

      for (i = 0; i < RandomItems / 2; i++) begin
         send_item(random_item(30));
         maybe_idle();
      end

      // long receiver hold-off while queries keep coming
      hold_req = 1'b1;
      for (i = 0; i < PressureItems; i++)
         send_item(random_item(85));

      for (i = 0; i < RandomItems / 2; i++) begin
         send_item(random_item(30));
         maybe_idle();
      end

      quiet = 1'b1;
      for (i = 0; i < QuietItems; i++)
         send_item(random_item(40));
      @(negedge clock);
      req_valid <= 1'b0;

      while (tracker.waiting() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      tracker.drain_check();

      $display("Run covered %0d pushes (%0d evicting the oldest sample) and %0d queries,",
               tracker.pushes, tracker.evictions, tracker.queries);
      $display("with %0d results compared and a %0d-cycle receiver hold-off.",
               tracker.compared, HoldCycles);
      if (tracker.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
